FILE: rtl/core/integer_to_text_formatter_defines.svh
// Assertion macros shared by the integer text formatter
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define ITF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger
`define ITF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/itf_pkg.sv
// Shared codes, controller/datapath handshake types and the digit character helper
package itf_pkg;

	// conversion codes
	localparam logic [2:0] CONV_D     = 3'd0;
	localparam logic [2:0] CONV_U     = 3'd1;
	localparam logic [2:0] CONV_XL    = 3'd2;
	localparam logic [2:0] CONV_XU    = 3'd3;
	localparam logic [2:0] CONV_O     = 3'd4;
	localparam logic [2:0] CONV_B     = 3'd5;
	localparam logic [2:0] CONV_P     = 3'd6;
	localparam logic [2:0] CONV_SPARE = 3'd7;

	// length modifier codes that narrow the argument
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_HH   = 3'd1;
	localparam logic [2:0] LEN_H    = 3'd2;

	// base selection
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_BIN = 2'd1;
	localparam logic [1:0] BASE_OCT = 2'd2;
	localparam logic [1:0] BASE_HEX = 2'd3;

	// result field widths
	localparam int DCNT_W = 7;
	localparam int CCNT_W = 2;

	// ASCII characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LX    = 8'h78;

	// commands from the controller
	typedef struct packed {
		logic load;
		logic dabble;
		logic digit;
		logic emit;
	} itf_cmd_t;

	// status towards the controller
	typedef struct packed {
		logic is_dec;
		logic skip;
		logic digits_done;
		logic out_free;
		logic emit_last;
	} itf_sts_t;

	// map a digit value to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else if (upper) begin
			r = CH_UA + {4'd0, d} - 8'd10;
		end else begin
			r = CH_LA + {4'd0, d} - 8'd10;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/integer_to_text_formatter.sv
// Top level of the integer text formatter: printf integer conversion to a two-character stream.
// Decimal runs the binary-to-BCD passes, then gathers the digits two at a time, then gives
// ceil(chars/2) output items, one per cycle while the output is not stalled; other bases skip
// the BCD passes. For a 64-bit argument binary takes the longest from one accept to the next.
// The output register lets the next item in while the last result still waits.
// arst_n clears the state machine and the output valid flag; no clearing pass is needed.
`include "integer_to_text_formatter_defines.svh"

module integer_to_text_formatter import itf_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [63:0]       value,
	input  logic [2:0]        conversion,
	input  logic [2:0]        length_mod,
	input  logic              flag_plus,
	input  logic              flag_space,
	input  logic              flag_alternate,
	input  logic              precision_zero,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CCNT_W-1:0] char_count,
	output logic [7:0]        first_char,
	output logic [7:0]        second_char,
	output logic              last,
	output logic [DCNT_W-1:0] digit_count
);

	localparam int STEPS = (VALUE_BITS + 1) / 2;

	itf_cmd_t cmd;
	itf_sts_t sts;

	// sequencing
	itf_ctrl #(
		.STEPS (STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// conversion and output
	itf_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.value          (value),
		.conversion     (conversion),
		.length_mod     (length_mod),
		.flag_plus      (flag_plus),
		.flag_space     (flag_space),
		.flag_alternate (flag_alternate),
		.precision_zero (precision_zero),
		.cmd            (cmd),
		.sts            (sts),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.char_count     (char_count),
		.first_char     (first_char),
		.second_char    (second_char),
		.last           (last),
		.digit_count    (digit_count)
	);

	// checks on the block's own behaviour
	`ITF_ASSERT_IMPL(a_count_range, clk, arst_n, out_valid, char_count != 2'd3, "item holds more than two characters")
	`ITF_ASSERT_IMPL(a_dcount_mid, clk, arst_n, out_valid && !last, digit_count == '0, "digit count shown before the final item")
	`ITF_ASSERT_IMPL(a_dcount_max, clk, arst_n, out_valid && last, digit_count <= DCNT_W'(VALUE_BITS), "digit count beyond argument width")
	`ITF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "second item taken while one is in work")

endmodule

FILE: rtl/core/itf_ctrl.sv
// Sequencing state machine: load, binary-to-BCD passes, digit gathering, text output
module itf_ctrl import itf_pkg::*; #(
	parameter int STEPS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  itf_sts_t sts,
	output itf_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DABBLE = 2'd1;
	localparam logic [1:0] ST_DIGITS = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	localparam int STEP_W = $clog2(STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [STEP_W-1:0] step_q;

	// take a new item only when idle
	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.skip) begin
						state_d = ST_EMIT;
					end else if (sts.is_dec) begin
						state_d = ST_DABBLE;
					end else begin
						state_d = ST_DIGITS;
					end
				end
			end
			ST_DABBLE: begin
				cmd.dabble = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				cmd.digit = 1'b1;
				if (sts.digits_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold state and the pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.dabble) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/itf_dp.sv
// Datapath: argument narrowing, sign and prefix, BCD conversion, digit store, output register
module itf_dp import itf_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       value,
	input  logic [2:0]        conversion,
	input  logic [2:0]        length_mod,
	input  logic              flag_plus,
	input  logic              flag_space,
	input  logic              flag_alternate,
	input  logic              precision_zero,
	input  itf_cmd_t          cmd,
	output itf_sts_t          sts,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [CCNT_W-1:0] char_count,
	output logic [7:0]        first_char,
	output logic [7:0]        second_char,
	output logic              last,
	output logic [DCNT_W-1:0] digit_count
);

	localparam int VB         = VALUE_BITS;
	localparam int STEPS      = (VB + 1) / 2;
	localparam int MAG_W      = 2 * STEPS;
	localparam int BCD_DIGITS = (VB * 30103) / 100000 + 1;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int DIG_W      = 4 * VB;
	localparam int W8         = (VB < 8)  ? VB : 8;
	localparam int W16        = (VB < 16) ? VB : 16;
	localparam int W32        = (VB < 32) ? VB : 32;

	// add three to every BCD digit of five or more
	function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] b);
		logic [BCD_W-1:0] r;
		r = b;
		for (int j = 0; j < BCD_DIGITS; j++) begin
			if (b[4*j +: 4] >= 4'd5) begin
				r[4*j +: 4] = b[4*j +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	// load-side signals
	logic [2:0]    conv_eff;
	logic          full_w;
	logic [VB-1:0] msk;
	logic [VB-1:0] x;
	logic          sign_bit;
	logic          neg;
	logic [VB-1:0] mag;
	logic          mag_zero;
	logic [1:0]    plen;
	logic [7:0]    pre0;
	logic [7:0]    pre1;
	logic [1:0]    base_ld;
	logic          upper_ld;

	// working registers
	logic [1:0]        base_q;
	logic              upper_q;
	logic [MAG_W-1:0]  mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [DIG_W-1:0]  dig_q;
	logic [DCNT_W-1:0] ndig_q;
	logic [DCNT_W-1:0] rd_q;
	logic [1:0]        pr_q;
	logic [7:0]        pre0_q;
	logic [7:0]        pre1_q;

	// output register
	logic              out_valid_q;
	logic [CCNT_W-1:0] ccnt_q;
	logic [7:0]        c0_q;
	logic [7:0]        c1_q;
	logic              last_q;
	logic [DCNT_W-1:0] dcnt_q;

	// BCD pass signals
	logic [BCD_W-1:0] bcd_a;
	logic [BCD_W-1:0] bcd_b;
	logic [BCD_W-1:0] bcd_c;
	logic [BCD_W-1:0] bcd_n;

	// digit step signals
	logic [3:0]       d0;
	logic [3:0]       d1;
	logic             one_left;
	logic             two_done;
	logic [MAG_W-1:0] r1;
	logic [MAG_W-1:0] r2;

	// emit signals
	logic [7:0]        top_ch;
	logic [7:0]        sec_ch;
	logic [7:0]        e0;
	logic [7:0]        e1;
	logic [CCNT_W-1:0] ecnt;
	logic [1:0]        use_n;
	logic [DCNT_W-1:0] rd_next;
	logic              emit_last;

	// narrow the argument, take the sign, choose base and prefix
	always_comb begin
		conv_eff = (conversion == CONV_SPARE) ? CONV_U : conversion;
		full_w   = (conv_eff == CONV_P) ||
			((length_mod != LEN_NONE) && (length_mod != LEN_HH) && (length_mod != LEN_H));
		for (int i = 0; i < VB; i++) begin
			msk[i] = full_w ||
				((length_mod == LEN_HH) && (i < W8)) ||
				((length_mod == LEN_H) && (i < W16)) ||
				((length_mod == LEN_NONE) && (i < W32));
		end
		x = value[VB-1:0] & msk;
		if (full_w) begin
			sign_bit = x[VB-1];
		end else if (length_mod == LEN_HH) begin
			sign_bit = x[W8-1];
		end else if (length_mod == LEN_H) begin
			sign_bit = x[W16-1];
		end else begin
			sign_bit = x[W32-1];
		end
		neg      = (conv_eff == CONV_D) && sign_bit;
		mag      = neg ? ((~(x | ~msk)) + VB'(1)) : x;
		mag_zero = (mag == '0);

		plen     = 2'd0;
		pre0     = CH_NUL;
		pre1     = CH_NUL;
		base_ld  = BASE_DEC;
		upper_ld = 1'b0;
		case (conv_eff)
			CONV_D: begin
				if (neg) begin
					pre0 = CH_MINUS;
					plen = 2'd1;
				end else if (flag_plus) begin
					pre0 = CH_PLUS;
					plen = 2'd1;
				end else if (flag_space) begin
					pre0 = CH_SPACE;
					plen = 2'd1;
				end
			end
			CONV_XL: begin
				base_ld = BASE_HEX;
				if (flag_alternate) begin
					pre0 = CH_ZERO;
					pre1 = CH_LX;
					plen = 2'd2;
				end
			end
			CONV_XU: begin
				base_ld  = BASE_HEX;
				upper_ld = 1'b1;
				if (flag_alternate) begin
					pre0 = CH_ZERO;
					pre1 = CH_UX;
					plen = 2'd2;
				end
			end
			CONV_O: begin
				base_ld = BASE_OCT;
				if (flag_alternate) begin
					pre0 = CH_ZERO;
					plen = 2'd1;
				end
			end
			CONV_B: begin
				base_ld = BASE_BIN;
				if (flag_alternate) begin
					pre0 = CH_ZERO;
					pre1 = CH_LB;
					plen = 2'd2;
				end
			end
			CONV_P: begin
				base_ld = BASE_HEX;
				pre0    = CH_ZERO;
				pre1    = CH_LX;
				plen    = 2'd2;
			end
			default: begin
				base_ld = BASE_DEC;
			end
		endcase

		// zero argument drops the alternate hex or binary prefix; octal keeps it only when no digit follows
		if (mag_zero && flag_alternate &&
			((conv_eff == CONV_XL) || (conv_eff == CONV_XU) || (conv_eff == CONV_B))) begin
			plen = 2'd0;
		end
		if (mag_zero && flag_alternate && (conv_eff == CONV_O) && !precision_zero) begin
			plen = 2'd0;
		end
	end

	// two double-dabble steps per cycle, top bits first
	always_comb begin
		bcd_a = add3(bcd_q);
		bcd_b = {bcd_a[BCD_W-2:0], mag_q[MAG_W-1]};
		bcd_c = add3(bcd_b);
		bcd_n = {bcd_c[BCD_W-2:0], mag_q[MAG_W-2]};
	end

	// peel up to two digits from the low end
	always_comb begin
		r1 = '0;
		r2 = '0;
		d0 = 4'd0;
		d1 = 4'd0;
		case (base_q)
			BASE_BIN: begin
				r1 = mag_q >> 1;
				r2 = mag_q >> 2;
				d0 = {3'd0, mag_q[0]};
				d1 = {3'd0, r1[0]};
			end
			BASE_OCT: begin
				r1 = mag_q >> 3;
				r2 = mag_q >> 6;
				d0 = {1'b0, mag_q[2:0]};
				d1 = {1'b0, r1[2:0]};
			end
			BASE_HEX: begin
				r1 = mag_q >> 4;
				r2 = mag_q >> 8;
				d0 = mag_q[3:0];
				d1 = r1[3:0];
			end
			default: begin
				d0 = bcd_q[3:0];
				d1 = bcd_q[7:4];
			end
		endcase
		if (base_q == BASE_DEC) begin
			one_left = (bcd_q[BCD_W-1:4] == '0);
			two_done = (bcd_q[BCD_W-1:8] == '0);
		end else begin
			one_left = (r1 == '0);
			two_done = (r2 == '0);
		end
	end

	// assemble the next pair of characters
	always_comb begin
		top_ch = digit_char(dig_q[DIG_W-1 -: 4], upper_q);
		sec_ch = digit_char(dig_q[DIG_W-5 -: 4], upper_q);
		e0     = CH_NUL;
		e1     = CH_NUL;
		ecnt   = 2'd0;
		use_n  = 2'd0;
		case (pr_q)
			2'd2: begin
				e0   = pre0_q;
				e1   = pre1_q;
				ecnt = 2'd2;
			end
			2'd1: begin
				e0 = pre0_q;
				if (rd_q != '0) begin
					e1    = top_ch;
					ecnt  = 2'd2;
					use_n = 2'd1;
				end else begin
					ecnt = 2'd1;
				end
			end
			default: begin
				if (rd_q >= DCNT_W'(2)) begin
					e0    = top_ch;
					e1    = sec_ch;
					ecnt  = 2'd2;
					use_n = 2'd2;
				end else if (rd_q == DCNT_W'(1)) begin
					e0    = top_ch;
					ecnt  = 2'd1;
					use_n = 2'd1;
				end
			end
		endcase
		rd_next   = rd_q - {{(DCNT_W-2){1'b0}}, use_n};
		emit_last = (rd_next == '0);
	end

	// advance the working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q  <= base_ld;
			upper_q <= upper_ld;
			mag_q   <= MAG_W'(mag);
			bcd_q   <= '0;
			ndig_q  <= '0;
			rd_q    <= '0;
			pr_q    <= plen;
			pre0_q  <= pre0;
			pre1_q  <= pre1;
		end else if (cmd.dabble) begin
			bcd_q <= bcd_n;
			mag_q <= {mag_q[MAG_W-3:0], 2'b00};
		end else if (cmd.digit) begin
			bcd_q <= bcd_q >> 8;
			mag_q <= r2;
			if (one_left) begin
				dig_q  <= {d0, dig_q[DIG_W-1:4]};
				ndig_q <= ndig_q + DCNT_W'(1);
				rd_q   <= rd_q + DCNT_W'(1);
			end else begin
				dig_q  <= {d1, d0, dig_q[DIG_W-1:8]};
				ndig_q <= ndig_q + DCNT_W'(2);
				rd_q   <= rd_q + DCNT_W'(2);
			end
		end else if (cmd.emit) begin
			pr_q <= 2'd0;
			rd_q <= rd_next;
			if (use_n == 2'd2) begin
				dig_q <= {dig_q[DIG_W-9:0], 8'd0};
			end else if (use_n == 2'd1) begin
				dig_q <= {dig_q[DIG_W-5:0], 4'd0};
			end
		end
	end

	// output item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ccnt_q <= ecnt;
			c0_q   <= e0;
			c1_q   <= e1;
			last_q <= emit_last;
			dcnt_q <= emit_last ? ndig_q : '0;
		end
	end

	// status towards the controller
	always_comb begin
		sts.is_dec      = (base_ld == BASE_DEC);
		sts.skip        = mag_zero && precision_zero;
		sts.digits_done = one_left || two_done;
		sts.out_free    = !out_valid_q || !out_stall;
		sts.emit_last   = emit_last;
	end

	assign out_valid   = out_valid_q;
	assign char_count  = ccnt_q;
	assign first_char  = c0_q;
	assign second_char = c1_q;
	assign last        = last_q;
	assign digit_count = dcnt_q;

endmodule
